>>> rtl/kps_pkg.sv
package kps_pkg;

  localparam int COL_W  = 5;
  localparam int ROW_W  = 2;
  localparam int CODE_W = 8;
  localparam int CFG_W  = 16;
  localparam int TPV_W  = 8;
  localparam int TIME_W = 32;
  localparam int IDX_W  = 2;

  localparam logic [IDX_W-1:0] CFG_REPEAT_FIRST = 2'd0;
  localparam logic [IDX_W-1:0] CFG_REPEAT_STEP  = 2'd1;
  localparam logic [IDX_W-1:0] CFG_ROW_TIME     = 2'd2;

  localparam logic [CFG_W-1:0] RST_REPEAT_FIRST = 16'd1000;
  localparam logic [CFG_W-1:0] RST_REPEAT_STEP  = 16'd200;
  localparam logic [TPV_W-1:0] RST_ROW_TIME     = 8'd20;
  localparam logic [TIME_W-1:0] RST_THRESHOLD   = 32'd1000;

  localparam logic CMD_SCAN = 1'b0;
  localparam logic CMD_POLL = 1'b1;

  localparam logic [1:0] KIND_PRESS   = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_LONG    = 2'd2;

  localparam logic [CODE_W-1:0] CODE_NONE    = 8'h00;
  localparam logic [CODE_W-1:0] CODE_PRESS   = 8'h01;
  localparam logic [CODE_W-1:0] CODE_RELEASE = 8'h21;
  localparam logic [CODE_W-1:0] CODE_LONG    = 8'h41;

  typedef struct packed {
    logic       found;
    logic [1:0] kind;
  } lane_evt_t;

  typedef struct packed {
    logic scan;
    logic poll;
  } lane_cmd_t;

  typedef struct packed {
    logic vld;
    logic last;
  } poll_step_t;

endpackage

>>> rtl/kps_lane.sv
module kps_lane #(
  parameter int ROWS             = 4,
  parameter int DEBOUNCE_SAMPLES = 4,
  parameter int ROW_SEL_W        = 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  kps_pkg::lane_cmd_t            cmd,
  input  logic [ROW_SEL_W-1:0]          row,
  input  logic                          col_bit,
  input  logic [kps_pkg::TPV_W-1:0]     row_time,
  input  logic [kps_pkg::CFG_W-1:0]     repeat_first,
  input  logic [kps_pkg::CFG_W-1:0]     repeat_step,
  output kps_pkg::lane_evt_t            evt_r
);

  logic [DEBOUNCE_SAMPLES-1:0]   hist_r [ROWS];
  logic                          stab_r [ROWS];
  logic                          rep_r  [ROWS];
  logic [kps_pkg::TIME_W-1:0]    pt_r   [ROWS];
  logic [kps_pkg::TIME_W-1:0]    thr_r  [ROWS];

  logic [DEBOUNCE_SAMPLES-1:0]   hist_nxt;
  logic                          stab_nxt;
  logic [kps_pkg::TIME_W-1:0]    pt_nxt;
  logic                          rep_nxt;
  logic [kps_pkg::TIME_W-1:0]    thr_nxt;
  kps_pkg::lane_evt_t            evt_nxt;
  logic [kps_pkg::TIME_W:0]      pt_sum;
  logic [kps_pkg::TIME_W:0]      thr_sum;
  logic [kps_pkg::TIME_W-1:0]    pt_cur;
  logic [kps_pkg::TIME_W-1:0]    thr_cur;

  assign pt_cur  = pt_r[row];
  assign thr_cur = thr_r[row];
  assign pt_sum  = {1'b0, pt_cur} + (kps_pkg::TIME_W+1)'(row_time);
  assign thr_sum = {1'b0, thr_cur} + (kps_pkg::TIME_W+1)'(repeat_step);

  // debounce on scan
  always_comb begin
    hist_nxt = {hist_r[row][DEBOUNCE_SAMPLES-2:0], col_bit};
    stab_nxt = stab_r[row];
    pt_nxt   = pt_cur;
    if (hist_nxt == '0) begin
      stab_nxt = 1'b0;
      pt_nxt   = pt_sum[kps_pkg::TIME_W] ? '1 : pt_sum[kps_pkg::TIME_W-1:0];
    end else if (hist_nxt == '1) begin
      stab_nxt = 1'b1;
      pt_nxt   = '0;
    end
  end

  // event check on poll
  always_comb begin
    evt_nxt = '0;
    rep_nxt = rep_r[row];
    thr_nxt = thr_cur;
    if (rep_r[row] != stab_r[row]) begin
      evt_nxt.found = 1'b1;
      evt_nxt.kind  = rep_r[row] ? kps_pkg::KIND_PRESS : kps_pkg::KIND_RELEASE;
      rep_nxt       = stab_r[row];
    end
    if (pt_cur != '0) begin
      if (pt_cur >= thr_cur) begin
        evt_nxt.found = 1'b1;
        evt_nxt.kind  = kps_pkg::KIND_LONG;
        thr_nxt       = thr_sum[kps_pkg::TIME_W] ? '1 : thr_sum[kps_pkg::TIME_W-1:0];
      end
    end else begin
      thr_nxt = kps_pkg::TIME_W'(repeat_first);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < ROWS; r++) begin
        hist_r[r] <= '1;
        stab_r[r] <= 1'b1;
        rep_r[r]  <= 1'b1;
        pt_r[r]   <= '0;
        thr_r[r]  <= kps_pkg::RST_THRESHOLD;
      end
      evt_r <= '0;
    end else begin
      if (cmd.scan) begin
        hist_r[row] <= hist_nxt;
        stab_r[row] <= stab_nxt;
        pt_r[row]   <= pt_nxt;
      end
      if (cmd.poll) begin
        rep_r[row] <= rep_nxt;
        thr_r[row] <= thr_nxt;
      end
      evt_r <= cmd.poll ? evt_nxt : '0;
    end
  end

endmodule

>>> rtl/kps_merge.sv
module kps_merge #(
  parameter int COLS      = 5,
  parameter int ROW_SEL_W = 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          clr,
  input  kps_pkg::poll_step_t           step,
  input  logic [ROW_SEL_W-1:0]          row,
  input  kps_pkg::lane_evt_t            evt [COLS],
  output logic                          done,
  output logic [kps_pkg::CODE_W-1:0]    code
);

  logic [kps_pkg::CODE_W-1:0] code_r;
  logic [kps_pkg::CODE_W-1:0] sel_col;
  logic [kps_pkg::CODE_W-1:0] base;
  logic [1:0]                 sel_kind;
  logic                       any;
  logic [kps_pkg::CODE_W-1:0] row_base;

  // last column with an event wins within the row
  always_comb begin
    any      = 1'b0;
    sel_col  = '0;
    sel_kind = kps_pkg::KIND_PRESS;
    for (int c = 0; c < COLS; c++) begin
      if (evt[c].found) begin
        any      = 1'b1;
        sel_col  = kps_pkg::CODE_W'(c);
        sel_kind = evt[c].kind;
      end
    end
  end

  always_comb begin
    case (sel_kind)
      kps_pkg::KIND_PRESS:   base = kps_pkg::CODE_PRESS;
      kps_pkg::KIND_RELEASE: base = kps_pkg::CODE_RELEASE;
      kps_pkg::KIND_LONG:    base = kps_pkg::CODE_LONG;
      default:               base = kps_pkg::CODE_NONE;
    endcase
  end

  assign row_base = kps_pkg::CODE_W'(kps_pkg::CODE_W'(row) * kps_pkg::CODE_W'(COLS));
  assign code     = (step.vld && any) ? base + row_base + sel_col : code_r;
  assign done     = step.vld && step.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_r <= kps_pkg::CODE_NONE;
    end else if (clr) begin
      code_r <= kps_pkg::CODE_NONE;
    end else begin
      code_r <= code;
    end
  end

endmodule

>>> rtl/matrix_keypad_scanner.sv
// channel  | handshake            | payload
// cfg      | cfg_we               | cfg_index, cfg_data
// in       | in_valid / in_stall  | in_command, in_column_bits
// out      | out_valid / out_stall| out_drive_row, out_key_code
//
// scan item: result passes the skid and output registers; next item waits for the skid
// poll item: all column lanes check one row per cycle, then merge
// sync reset: all keys released, press times cleared, registers at defaults
// one finished result waits in a skid register while the output is stalled
module matrix_keypad_scanner #(
  parameter int ROWS             = 4,
  parameter int COLS             = 5,
  parameter int DEBOUNCE_SAMPLES = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [kps_pkg::IDX_W-1:0]     cfg_index,
  input  logic [kps_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_command,
  input  logic [kps_pkg::COL_W-1:0]     in_column_bits,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [kps_pkg::ROW_W-1:0]     out_drive_row,
  output logic [kps_pkg::CODE_W-1:0]    out_key_code
);

  localparam int ROW_SEL_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [ROW_SEL_W-1:0] LAST_ROW = ROW_SEL_W'(ROWS - 1);

  logic [kps_pkg::CFG_W-1:0]  repeat_first_r;
  logic [kps_pkg::CFG_W-1:0]  repeat_step_r;
  logic [kps_pkg::TPV_W-1:0]  row_time_r;

  logic [ROW_SEL_W-1:0]       row_r;
  logic [ROW_SEL_W-1:0]       row_nxt;
  logic [ROW_SEL_W-1:0]       prow_r;
  logic [ROW_SEL_W-1:0]       step_row_r;
  logic [ROW_SEL_W-1:0]       lane_row;
  logic                       walk_r;
  logic                       busy_r;
  kps_pkg::poll_step_t        step_r;

  logic                       res_v_r;
  logic [kps_pkg::ROW_W-1:0]  res_row_r;
  logic [kps_pkg::CODE_W-1:0] res_code_r;
  logic                       out_valid_r;
  logic [kps_pkg::ROW_W-1:0]  out_row_r;
  logic [kps_pkg::CODE_W-1:0] out_code_r;

  logic                       in_accept;
  logic                       scan_go;
  logic                       poll_go;
  logic                       out_ready;
  logic                       mrg_done;
  logic [kps_pkg::CODE_W-1:0] mrg_code;
  logic [ROW_SEL_W+1:0]       row_ext;
  kps_pkg::lane_cmd_t         lane_cmd;
  kps_pkg::lane_evt_t         lane_evt [COLS];

  assign in_stall  = busy_r | res_v_r;
  assign in_accept = in_valid & ~in_stall;
  assign scan_go   = in_accept && (in_command == kps_pkg::CMD_SCAN);
  assign poll_go   = in_accept && (in_command == kps_pkg::CMD_POLL);
  assign out_ready = ~out_valid_r | ~out_stall;

  assign row_nxt  = (row_r == LAST_ROW) ? '0 : row_r + 1'b1;
  assign row_ext  = (ROW_SEL_W+2)'(row_nxt);
  assign lane_row = walk_r ? prow_r : row_r;

  assign lane_cmd.scan = scan_go;
  assign lane_cmd.poll = walk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repeat_first_r <= kps_pkg::RST_REPEAT_FIRST;
      repeat_step_r  <= kps_pkg::RST_REPEAT_STEP;
      row_time_r     <= kps_pkg::RST_ROW_TIME;
    end else if (cfg_we) begin
      case (cfg_index)
        kps_pkg::CFG_REPEAT_FIRST: repeat_first_r <= cfg_data;
        kps_pkg::CFG_REPEAT_STEP:  repeat_step_r  <= cfg_data;
        kps_pkg::CFG_ROW_TIME:     row_time_r     <= cfg_data[kps_pkg::TPV_W-1:0];
        default: ;
      endcase
    end
  end

  for (genvar c = 0; c < COLS; c++) begin : g_lane
    logic col_bit;
    if (c < kps_pkg::COL_W) begin : g_in
      assign col_bit = in_column_bits[c];
    end else begin : g_zero
      assign col_bit = 1'b0;
    end

    kps_lane #(
      .ROWS             (ROWS),
      .DEBOUNCE_SAMPLES (DEBOUNCE_SAMPLES),
      .ROW_SEL_W        (ROW_SEL_W)
    ) u_lane (
      .clk          (clk),
      .rst_n        (rst_n),
      .cmd          (lane_cmd),
      .row          (lane_row),
      .col_bit      (col_bit),
      .row_time     (row_time_r),
      .repeat_first (repeat_first_r),
      .repeat_step  (repeat_step_r),
      .evt_r        (lane_evt[c])
    );
  end

  kps_merge #(
    .COLS      (COLS),
    .ROW_SEL_W (ROW_SEL_W)
  ) u_merge (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (poll_go),
    .step  (step_r),
    .row   (step_row_r),
    .evt   (lane_evt),
    .done  (mrg_done),
    .code  (mrg_code)
  );

  // poll walk over rows
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      prow_r <= '0;
      walk_r <= 1'b0;
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      if (scan_go) begin
        row_r <= row_nxt;
      end
      if (poll_go) begin
        walk_r <= 1'b1;
        busy_r <= 1'b1;
        prow_r <= '0;
      end else if (walk_r) begin
        prow_r <= prow_r + 1'b1;
        if (prow_r == LAST_ROW) begin
          walk_r <= 1'b0;
        end
      end
      if (mrg_done) begin
        busy_r <= 1'b0;
      end
      step_r.vld  <= walk_r;
      step_r.last <= walk_r && (prow_r == LAST_ROW);
    end
  end

  always_ff @(posedge clk) begin
    step_row_r <= prow_r;
  end

  // skid stage and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (scan_go || mrg_done) begin
        res_v_r <= 1'b1;
      end else if (out_ready) begin
        res_v_r <= 1'b0;
      end
      if (out_ready) begin
        out_valid_r <= res_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_go) begin
      res_row_r  <= row_ext[kps_pkg::ROW_W-1:0];
      res_code_r <= kps_pkg::CODE_NONE;
    end else if (mrg_done) begin
      res_row_r  <= kps_pkg::ROW_W'(row_r);
      res_code_r <= mrg_code;
    end
    if (out_ready) begin
      out_row_r  <= res_row_r;
      out_code_r <= res_code_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_drive_row = out_row_r;
  assign out_key_code  = out_code_r;

endmodule

>>> tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROWS = 4;
  localparam int COLS = 5;
  localparam int DEBOUNCE = 4;
  localparam int NKEYS = ROWS * COLS;
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic                      command;
    logic [kps_pkg::COL_W-1:0] column_bits;
  } keypad_item_t;

  typedef struct packed {
    logic [kps_pkg::ROW_W-1:0]  drive_row;
    logic [kps_pkg::CODE_W-1:0] key_code;
  } key_result_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_we = 1'b0;
  logic [kps_pkg::IDX_W-1:0]  cfg_index = kps_pkg::CFG_REPEAT_FIRST;
  logic [kps_pkg::CFG_W-1:0]  cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       in_command = kps_pkg::CMD_SCAN;
  logic [kps_pkg::COL_W-1:0]  in_column_bits = '1;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [kps_pkg::ROW_W-1:0]  out_drive_row;
  logic [kps_pkg::CODE_W-1:0] out_key_code;

  // keypad state as the block should hold it
  logic [DEBOUNCE-1:0]        key_hist [NKEYS];
  logic                       stable_lvl [NKEYS];
  logic                       reported_lvl [NKEYS];
  logic [kps_pkg::TIME_W-1:0] held_time [NKEYS];
  logic [kps_pkg::TIME_W-1:0] repeat_at [NKEYS];
  logic [kps_pkg::ROW_W-1:0]  scan_row;
  logic [kps_pkg::CFG_W-1:0]  first_ms;
  logic [kps_pkg::CFG_W-1:0]  step_ms;
  logic [kps_pkg::TPV_W-1:0]  row_time;

  keypad_item_t pending_items [$];
  key_result_t  expected_codes [$];
  keypad_item_t next_item;
  key_result_t  new_result;
  key_result_t  want;

  bit key_down [NKEYS];
  int gen_row = 0;
  int error_count = 0;
  int accepted_items = 0;
  int send_gap = 0;
  int stall_cnt = 0;
  int hold_cnt = 0;
  int quiet_cycles = 0;
  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;
  bit hold_req = 1'b0;

  matrix_keypad_scanner u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_column_bits (in_column_bits),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_drive_row  (out_drive_row),
    .out_key_code   (out_key_code)
  );

  always #5 clk = ~clk;

  function automatic logic [kps_pkg::TIME_W-1:0] sat_add(
      input logic [kps_pkg::TIME_W-1:0] a, input logic [kps_pkg::TIME_W-1:0] b);
    logic [kps_pkg::TIME_W:0] s;
    s = a + b;
    return s[kps_pkg::TIME_W] ? '1 : s[kps_pkg::TIME_W-1:0];
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    else if (r < 92) return $urandom_range(1, 3);
    else if (r < 98) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  function automatic void reset_keypad_model();
    int k;
    for (k = 0; k < NKEYS; k++) begin
      key_hist[k] = '1;
      stable_lvl[k] = 1'b1;
      reported_lvl[k] = 1'b1;
      held_time[k] = '0;
      repeat_at[k] = kps_pkg::RST_THRESHOLD;
    end
    scan_row = '0;
    first_ms = kps_pkg::RST_REPEAT_FIRST;
    step_ms = kps_pkg::RST_REPEAT_STEP;
    row_time = kps_pkg::RST_ROW_TIME;
  endfunction

  function automatic void write_register(input logic [kps_pkg::IDX_W-1:0] idx,
                                         input logic [kps_pkg::CFG_W-1:0] data);
    case (idx)
      kps_pkg::CFG_REPEAT_FIRST: first_ms = data;
      kps_pkg::CFG_REPEAT_STEP: step_ms = data;
      kps_pkg::CFG_ROW_TIME: row_time = data[kps_pkg::TPV_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic key_result_t predict_key_result(
      input logic command, input logic [kps_pkg::COL_W-1:0] cols);
    key_result_t r;
    int c;
    int k;
    logic [DEBOUNCE-1:0] h;
    r.key_code = kps_pkg::CODE_NONE;
    if (command == kps_pkg::CMD_SCAN) begin
      for (c = 0; c < COLS; c++) begin
        k = scan_row * COLS + c;
        h = {key_hist[k][DEBOUNCE-2:0], cols[c]};
        key_hist[k] = h;
        if (h == '0) begin
          stable_lvl[k] = 1'b0;
          held_time[k] = sat_add(held_time[k], kps_pkg::TIME_W'(row_time));
        end else if (h == '1) begin
          stable_lvl[k] = 1'b1;
          held_time[k] = '0;
        end
      end
      scan_row = (scan_row == ROWS - 1) ? '0 : scan_row + 1'b1;
    end else begin
      for (k = 0; k < NKEYS; k++) begin
        if (reported_lvl[k] != stable_lvl[k]) begin
          r.key_code = reported_lvl[k] ? kps_pkg::CODE_PRESS + kps_pkg::CODE_W'(k)
                                       : kps_pkg::CODE_RELEASE + kps_pkg::CODE_W'(k);
          reported_lvl[k] = stable_lvl[k];
        end
        if (held_time[k] > 0) begin
          if (held_time[k] >= repeat_at[k]) begin
            r.key_code = kps_pkg::CODE_LONG + kps_pkg::CODE_W'(k);
            repeat_at[k] = sat_add(repeat_at[k], kps_pkg::TIME_W'(step_ms));
          end
        end else begin
          repeat_at[k] = kps_pkg::TIME_W'(first_ms);
        end
      end
    end
    r.drive_row = scan_row;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
      reset_keypad_model();
    end else begin
      if (cfg_we) write_register(cfg_index, cfg_data);
      if (in_valid && !in_stall) begin
        new_result = predict_key_result(in_command, in_column_bits);
        expected_codes.push_back(new_result);
        accepted_items++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          next_item = pending_items.pop_front();
          in_valid <= 1'b1;
          in_command <= next_item.command;
          in_column_bits <= next_item.column_bits;
          send_gap = send_idle ? pick_gap() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_cnt = 0;
      hold_cnt = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_codes.size() == 0) begin
          $display("%0t unexpected result: expected none, actual row %0d code %02h",
                   $time, out_drive_row, out_key_code);
          error_count++;
        end else begin
          want = expected_codes.pop_front();
          if (out_drive_row !== want.drive_row) begin
            $display("%0t drive_row mismatch: expected %0d, actual %0d",
                     $time, want.drive_row, out_drive_row);
            error_count++;
          end
          if (out_key_code !== want.key_code) begin
            $display("%0t key_code mismatch: expected %02h, actual %02h",
                     $time, want.key_code, out_key_code);
            error_count++;
          end
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1'b1;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_cnt = recv_idle ? pick_gap() : 0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic add_item(input logic command, input logic [kps_pkg::COL_W-1:0] cols);
    keypad_item_t item;
    item.command = command;
    item.column_bits = cols;
    pending_items.push_back(item);
    if (command == kps_pkg::CMD_SCAN) gen_row = (gen_row + 1) % ROWS;
  endtask

  // key presses held for a while, with contact bounce and some noise, mixed with polls
  task automatic add_random(input int count);
    int n;
    int c;
    logic [kps_pkg::COL_W-1:0] cols;
    for (n = 0; n < count; n++) begin
      if ($urandom_range(0, 3) == 0) begin
        add_item(kps_pkg::CMD_POLL, kps_pkg::COL_W'($urandom));
      end else begin
        if ($urandom_range(0, 9) == 0) key_down[$urandom_range(0, NKEYS - 1)] ^= 1'b1;
        if ($urandom_range(0, 19) == 0) begin
          cols = kps_pkg::COL_W'($urandom);
        end else begin
          for (c = 0; c < COLS; c++)
            cols[c] = ~key_down[gen_row * COLS + c] ^ ($urandom_range(0, 24) == 0);
        end
        add_item(kps_pkg::CMD_SCAN, cols);
      end
    end
  endtask

  task automatic write_cfg(input logic [kps_pkg::IDX_W-1:0] idx,
                           input logic [kps_pkg::CFG_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_registers(input logic [kps_pkg::CFG_W-1:0] first,
                               input logic [kps_pkg::CFG_W-1:0] step,
                               input logic [kps_pkg::CFG_W-1:0] per_row);
    write_cfg(kps_pkg::CFG_REPEAT_FIRST, first);
    write_cfg(kps_pkg::CFG_REPEAT_STEP, step);
    write_cfg(kps_pkg::CFG_ROW_TIME, per_row);
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || expected_codes.size() > 0 || in_valid)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  initial begin
    int base;
    int n;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset registers, all keys pressed then partly released
    add_item(kps_pkg::CMD_POLL, 5'h00);
    add_item(kps_pkg::CMD_SCAN, 5'h1f);
    for (n = 0; n < 16; n++) add_item(kps_pkg::CMD_SCAN, 5'h00);
    add_item(kps_pkg::CMD_POLL, 5'h1f);
    add_item(kps_pkg::CMD_POLL, 5'h00);
    add_item(kps_pkg::CMD_SCAN, 5'b01010);
    add_item(kps_pkg::CMD_SCAN, 5'b10101);
    add_item(kps_pkg::CMD_POLL, 5'h15);
    add_random(200);
    wait_drained();

    send_idle = 1'b0;
    recv_idle = 1'b0;
    set_registers(16'h0000, 16'h0000, 16'h00ff);
    add_random(200);
    wait_drained();

    send_idle = 1'b1;
    recv_idle = 1'b1;
    set_registers(16'hffff, 16'hffff, 16'hff00);
    add_random(200);
    wait_drained();

    // long output hold-off while items keep coming
    send_idle = 1'b0;
    set_registers(16'd60, 16'd40, 16'd20);
    base = accepted_items;
    add_random(350);
    while (accepted_items < base + 40) @(negedge clk);
    hold_req = 1'b1;
    @(negedge clk);
    wait_drained();

    send_idle = 1'b1;
    set_registers(16'd1, 16'hffff, 16'd1);
    add_random(200);
    wait_drained();

    set_registers(kps_pkg::CFG_W'($urandom_range(0, 400)),
                  kps_pkg::CFG_W'($urandom_range(0, 100)),
                  kps_pkg::CFG_W'($urandom_range(1, 50)));
    add_random(300);
    wait_drained();

    repeat (20) @(negedge clk);
    if (error_count == 0 && expected_codes.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> matrix_keypad_scanner.f
rtl/kps_pkg.sv
rtl/kps_lane.sv
rtl/kps_merge.sv
rtl/matrix_keypad_scanner.sv
tb/testbench.sv
